[hw/rtl/gmhp_pkg.sv]
`timescale 1ns / 1ps

package gmhp_pkg;

    // width of the byte position counter
    localparam int POSITION_BITS = 32;
    localparam int OFFSET_W      = 32;
    localparam int LENGTH_W      = 32;
    localparam int LIMIT_W       = (POSITION_BITS > LENGTH_W) ? POSITION_BITS : LENGTH_W;
    localparam int FLAG_W        = 5;
    localparam int XLEN_W        = 16;

    localparam logic [LIMIT_W-1:0] POS_MAX_L = LIMIT_W'({POSITION_BITS{1'b1}});

    localparam logic [7:0] MAGIC_ID1      = 8'h1F;
    localparam logic [7:0] MAGIC_ID2      = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    localparam int MIN_MEMBER_LEN = 18;
    localparam int TRAILER_LEN    = 8;
    localparam int FIXED_HDR_LEN  = 10;
    localparam int HCRC_LEN       = 2;

    // fixed header byte positions
    localparam int POS_ID2   = 1;
    localparam int POS_CM    = 2;
    localparam int POS_FLAGS = 3;

    // flag bit positions
    localparam int FB_HCRC    = 1;
    localparam int FB_EXTRA   = 2;
    localparam int FB_NAME    = 3;
    localparam int FB_COMMENT = 4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_XLEN_LO = 3'd1,
        PH_XLEN_HI = 3'd2,
        PH_XSKIP   = 3'd3,
        PH_NAME    = 3'd4,
        PH_COMMENT = 3'd5,
        PH_HCRC    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_SHORT   = 2'd1,
        STAT_MAGIC   = 2'd2,
        STAT_OVERRUN = 2'd3
    } status_t;

    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        phase_t                   phase;
        logic [FLAG_W-1:0]        flags;
        logic [XLEN_W-1:0]        extra;
        logic [POSITION_BITS-1:0] limit;
        logic                     given;
    } parse_state_t;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] offset;
    } result_t;

endpackage

[hw/rtl/gmhp_in_if.sv]
`timescale 1ns / 1ps

interface gmhp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_of_member;
    logic [31:0] member_length;

    modport source (
        output valid,
        output data_byte,
        output first_of_member,
        output member_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  first_of_member,
        input  member_length,
        output ready
    );
endinterface

[hw/rtl/gmhp_out_if.sv]
`timescale 1ns / 1ps

interface gmhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  header_status;
    logic [31:0] deflate_offset;

    modport source (
        output valid,
        output header_status,
        output deflate_offset,
        input  ready
    );

    modport sink (
        input  valid,
        input  header_status,
        input  deflate_offset,
        output ready
    );
endinterface

[hw/rtl/gmhp_step.sv]
`timescale 1ns / 1ps

module gmhp_step import gmhp_pkg::*; (
    input  parse_state_t          cur,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_member,
    input  logic [LENGTH_W-1:0]   member_length,
    output parse_state_t          nxt,
    output logic                  res_valid,
    output result_t               res
);

    // where the search for the next selected field starts
    typedef enum logic [2:0] {
        EN_EXTRA   = 3'd1,
        EN_NAME    = 3'd2,
        EN_COMMENT = 3'd3,
        EN_HCRC    = 3'd4,
        EN_END     = 3'd5
    } enter_t;

    typedef struct packed {
        logic    give;
        status_t status;
        phase_t  phase;
        logic    set_crc;
    } enter_res_t;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] room;
    logic                     room_zero;
    logic                     room_lt2;
    logic [LIMIT_W-1:0]       len_diff;
    logic [LIMIT_W-1:0]       len_lim;
    logic [LIMIT_W-1:0]       pos_ext;
    logic [XLEN_W-1:0]        xlen;
    logic [XLEN_W-1:0]        extra_dec;
    enter_t                   en_stage;
    enter_res_t               en;
    logic                     take_enter;
    logic                     give;
    status_t                  give_status;

    function automatic enter_res_t do_enter(enter_t stage, logic [FLAG_W-1:0] flags,
                                            logic lt2, logic zero);
        enter_res_t r;
        r = '{give: 1'b0, status: STAT_OK, phase: PH_HEADER, set_crc: 1'b0};
        if (stage <= EN_EXTRA && flags[FB_EXTRA])
        begin
            r.give   = lt2;
            r.status = STAT_OVERRUN;
            r.phase  = PH_XLEN_LO;
        end
        else if (stage <= EN_NAME && flags[FB_NAME])
        begin
            r.give   = zero;
            r.status = STAT_OVERRUN;
            r.phase  = PH_NAME;
        end
        else if (stage <= EN_COMMENT && flags[FB_COMMENT])
        begin
            r.give   = zero;
            r.status = STAT_OVERRUN;
            r.phase  = PH_COMMENT;
        end
        else if (stage <= EN_HCRC && flags[FB_HCRC])
        begin
            r.give    = lt2;
            r.status  = STAT_OVERRUN;
            r.phase   = PH_HCRC;
            r.set_crc = 1'b1;
        end
        else
        begin
            // end of header: need at least one deflate byte
            r.give   = 1'b1;
            r.status = zero ? STAT_OVERRUN : STAT_OK;
        end
        return r;
    endfunction

    assign pos_inc   = cur.pos + POSITION_BITS'(1);
    assign room      = (cur.limit > pos_inc) ? (cur.limit - pos_inc) : '0;
    assign room_zero = (room == '0);
    assign room_lt2  = (room < POSITION_BITS'(2));
    assign len_diff  = LIMIT_W'(member_length) - LIMIT_W'(TRAILER_LEN);
    assign len_lim   = (len_diff > POS_MAX_L) ? POS_MAX_L : len_diff;
    assign pos_ext   = LIMIT_W'(pos_inc);
    assign xlen      = {data_byte, cur.extra[7:0]};
    assign extra_dec = cur.extra - XLEN_W'(1);

    always_comb
    begin
        case (cur.phase)
            PH_HEADER:  en_stage = EN_EXTRA;
            PH_XLEN_HI: en_stage = EN_NAME;
            PH_XSKIP:   en_stage = EN_NAME;
            PH_NAME:    en_stage = EN_COMMENT;
            PH_COMMENT: en_stage = EN_HCRC;
            default:    en_stage = EN_END;
        endcase
    end

    assign en = do_enter(en_stage, cur.flags, room_lt2, room_zero);

    always_comb
    begin
        nxt         = cur;
        take_enter  = 1'b0;
        give        = 1'b0;
        give_status = STAT_OK;

        if (first_of_member)
        begin
            nxt.given = 1'b0;
            nxt.phase = PH_HEADER;
            nxt.pos   = '0;
            nxt.flags = '0;
            nxt.extra = '0;
            nxt.limit = '0;
            if (member_length < LENGTH_W'(MIN_MEMBER_LEN))
            begin
                give        = 1'b1;
                give_status = STAT_SHORT;
            end
            else
            begin
                nxt.limit = POSITION_BITS'(len_lim);
                if (data_byte != MAGIC_ID1)
                begin
                    give        = 1'b1;
                    give_status = STAT_MAGIC;
                end
                else
                begin
                    nxt.pos = POSITION_BITS'(1);
                end
            end
        end
        else if (!cur.given)
        begin
            case (cur.phase)
                PH_HEADER:
                begin
                    if ((cur.pos == POSITION_BITS'(POS_ID2) && data_byte != MAGIC_ID2) ||
                        (cur.pos == POSITION_BITS'(POS_CM) && data_byte != METHOD_DEFLATE))
                    begin
                        give        = 1'b1;
                        give_status = STAT_MAGIC;
                    end
                    else
                    begin
                        if (cur.pos == POSITION_BITS'(POS_FLAGS))
                        begin
                            nxt.flags = data_byte[FLAG_W-1:0];
                        end
                        nxt.pos    = pos_inc;
                        take_enter = (pos_inc >= POSITION_BITS'(FIXED_HDR_LEN));
                    end
                end
                PH_XLEN_LO:
                begin
                    nxt.extra = XLEN_W'(data_byte);
                    nxt.pos   = pos_inc;
                    nxt.phase = PH_XLEN_HI;
                end
                PH_XLEN_HI:
                begin
                    nxt.extra = xlen;
                    nxt.pos   = pos_inc;
                    if (room < POSITION_BITS'(xlen))
                    begin
                        give        = 1'b1;
                        give_status = STAT_OVERRUN;
                    end
                    else if (xlen == '0)
                    begin
                        take_enter = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = PH_XSKIP;
                    end
                end
                PH_XSKIP, PH_HCRC:
                begin
                    nxt.pos    = pos_inc;
                    nxt.extra  = extra_dec;
                    take_enter = (extra_dec == '0);
                end
                PH_NAME, PH_COMMENT:
                begin
                    nxt.pos = pos_inc;
                    if (data_byte == 8'h00)
                    begin
                        take_enter = 1'b1;
                    end
                    else if (room_zero)
                    begin
                        give        = 1'b1;
                        give_status = STAT_OVERRUN;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end

        if (take_enter)
        begin
            if (en.give)
            begin
                give        = 1'b1;
                give_status = en.status;
            end
            else
            begin
                nxt.phase = en.phase;
                if (en.set_crc)
                begin
                    nxt.extra = XLEN_W'(HCRC_LEN);
                end
            end
        end

        if (give)
        begin
            nxt.given = 1'b1;
        end
    end

    assign res_valid  = give;
    assign res.status = give_status;
    assign res.offset = (give_status == STAT_OK) ? pos_ext[OFFSET_W-1:0] : '0;

endmodule

[hw/rtl/gzip_member_header_parser.sv]
`timescale 1ns / 1ps
// a byte's result goes through the input register and then the result register
// throughput: one byte per cycle, sustained, as long as results are taken when shown
// the rate is set by the single pass from the input register through the step logic
// reset: both channels empty, parser idle; bytes are ignored until a first-of-member beat
// reset takes effect at once (asynchronous, active low) and releases on the clock

module gzip_member_header_parser import gmhp_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    gmhp_in_if.sink        member_bytes,
    gmhp_out_if.source     header_result
);

    // input register: holds one beat until the step logic can use it
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_first_reg;
    logic [LENGTH_W-1:0]   in_len_reg;

    // parser state
    parse_state_t          state_reg;
    parse_state_t          state_next;

    // result register
    logic                  out_valid_reg;
    result_t               out_res_reg;

    logic                  res_valid;
    result_t               res;
    logic                  advance;

    localparam parse_state_t STATE_RESET = '{
        pos:   '0,
        phase: PH_HEADER,
        flags: '0,
        extra: '0,
        limit: '0,
        given: 1'b1
    };

    // a held byte moves on when the result register is free or being emptied
    assign advance            = in_valid_reg && (!out_valid_reg || header_result.ready);
    assign member_bytes.ready = !in_valid_reg || advance;

    gmhp_step u_step (
        .cur             (state_reg),
        .data_byte       (in_byte_reg),
        .first_of_member (in_first_reg),
        .member_length   (in_len_reg),
        .nxt             (state_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (member_bytes.ready)
        begin
            in_valid_reg <= member_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (member_bytes.valid && member_bytes.ready)
        begin
            in_byte_reg  <= member_bytes.data_byte;
            in_first_reg <= member_bytes.first_of_member;
            in_len_reg   <= member_bytes.member_length;
        end
    end

    // parser state advances once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register; a byte that gives no result just drains it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (header_result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign header_result.valid          = out_valid_reg;
    assign header_result.header_status  = out_res_reg.status;
    assign header_result.deflate_offset = out_res_reg.offset;

    // a result always closes the member
    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> state_reg.given)
        else $error("result given but parser still open");

    // bytes after the result, short of a new member, leave the state alone
    a_ignored_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_first_reg && state_reg.given |=> state_reg == $past(state_reg))
        else $error("ignored byte changed parser state");

    // no consumed byte, no state change
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parser state moved without a byte");

    // error results carry a zero offset
    a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.status != STAT_OK |-> out_res_reg.offset == '0)
        else $error("error result with nonzero offset");

    // deflate data can never begin inside the fixed header
    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.status == STAT_OK
            |-> out_res_reg.offset >= OFFSET_W'(FIXED_HDR_LEN))
        else $error("ok result inside fixed header");

endmodule

[verif/gmhp_header_checker.sv]
`timescale 1ns / 1ps

module gmhp_header_checker import gmhp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    gmhp_in_if   bytes_mon,
    gmhp_out_if  result_mon,
    output int   mismatches,
    output int   outstanding
);

    // where the search for the next selected field starts
    localparam int STAGE_EXTRA   = 1;
    localparam int STAGE_NAME    = 2;
    localparam int STAGE_COMMENT = 3;
    localparam int STAGE_HCRC    = 4;
    localparam int STAGE_END     = 5;
    localparam int XLEN_BYTES    = 2;

    logic [63:0]       pos_q;
    logic [63:0]       limit_q;
    phase_t            phase_q;
    logic [FLAG_W-1:0] flags_q;
    logic [XLEN_W-1:0] extra_q;
    logic              decided_q;
    result_t           pending_verdicts[$];
    int                mismatch_total = 0;
    int                verdicts_due   = 0;

    assign mismatches  = mismatch_total;
    assign outstanding = verdicts_due;

    function automatic void restart_parse();
        pos_q   = '0;
        limit_q = '0;
        phase_q = PH_HEADER;
        flags_q = '0;
        extra_q = '0;
    endfunction

    function automatic logic [63:0] room_left();
        return (pos_q < limit_q) ? limit_q - pos_q : 64'd0;
    endfunction

    function automatic void post_verdict(input status_t status);
        result_t verdict;
        decided_q      = 1'b1;
        verdict.status = status;
        verdict.offset = (status == STAT_OK) ? pos_q[OFFSET_W-1:0] : '0;
        pending_verdicts.push_back(verdict);
    endfunction

    function automatic void next_field(input int stage);
        if (stage <= STAGE_EXTRA && flags_q[FB_EXTRA])
        begin
            if (room_left() < XLEN_BYTES) post_verdict(STAT_OVERRUN);
            else phase_q = PH_XLEN_LO;
        end
        else if (stage <= STAGE_NAME && flags_q[FB_NAME])
        begin
            if (room_left() == 0) post_verdict(STAT_OVERRUN);
            else phase_q = PH_NAME;
        end
        else if (stage <= STAGE_COMMENT && flags_q[FB_COMMENT])
        begin
            if (room_left() == 0) post_verdict(STAT_OVERRUN);
            else phase_q = PH_COMMENT;
        end
        else if (stage <= STAGE_HCRC && flags_q[FB_HCRC])
        begin
            if (room_left() < HCRC_LEN)
                post_verdict(STAT_OVERRUN);
            else
            begin
                extra_q = XLEN_W'(HCRC_LEN);
                phase_q = PH_HCRC;
            end
        end
        else if (room_left() == 0)
            post_verdict(STAT_OVERRUN);
        else
            post_verdict(STAT_OK);
    endfunction

    function automatic void parse_member_byte(input logic [7:0] b, input logic first,
                                              input logic [LENGTH_W-1:0] len);
        if (first)
        begin
            decided_q = 1'b0;
            restart_parse();
            if (len < MIN_MEMBER_LEN)
                post_verdict(STAT_SHORT);
            else
            begin
                limit_q = 64'(len) - TRAILER_LEN;
                if (limit_q > 64'(POS_MAX_L)) limit_q = 64'(POS_MAX_L);
                if (b != MAGIC_ID1) post_verdict(STAT_MAGIC);
                else pos_q = 64'd1;
            end
        end
        else if (!decided_q)
        begin
            case (phase_q)
                PH_HEADER:
                begin
                    if (pos_q == POS_ID2 && b != MAGIC_ID2)
                        post_verdict(STAT_MAGIC);
                    else if (pos_q == POS_CM && b != METHOD_DEFLATE)
                        post_verdict(STAT_MAGIC);
                    else
                    begin
                        if (pos_q == POS_FLAGS) flags_q = b[FLAG_W-1:0];
                        pos_q++;
                        if (pos_q >= FIXED_HDR_LEN) next_field(STAGE_EXTRA);
                    end
                end
                PH_XLEN_LO:
                begin
                    extra_q = {8'h00, b};
                    pos_q++;
                    phase_q = PH_XLEN_HI;
                end
                PH_XLEN_HI:
                begin
                    extra_q = {b, extra_q[7:0]};
                    pos_q++;
                    if (room_left() < extra_q) post_verdict(STAT_OVERRUN);
                    else if (extra_q == 0) next_field(STAGE_NAME);
                    else phase_q = PH_XSKIP;
                end
                PH_XSKIP:
                begin
                    pos_q++;
                    extra_q--;
                    if (extra_q == 0) next_field(STAGE_NAME);
                end
                PH_NAME, PH_COMMENT:
                begin
                    pos_q++;
                    if (b == 8'h00)
                        next_field(phase_q == PH_NAME ? STAGE_COMMENT : STAGE_HCRC);
                    else if (room_left() == 0)
                        post_verdict(STAT_OVERRUN);
                end
                PH_HCRC:
                begin
                    pos_q++;
                    extra_q--;
                    if (extra_q == 0) next_field(STAGE_END);
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            restart_parse();
            decided_q = 1'b1;
            pending_verdicts.delete();
        end
        else
        begin
            if (bytes_mon.valid && bytes_mon.ready)
                parse_member_byte(bytes_mon.data_byte, bytes_mon.first_of_member,
                                  bytes_mon.member_length);
            if (result_mon.valid && result_mon.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result beat, status %0d offset %0d", $time,
                             result_mon.header_status, result_mon.deflate_offset);
                    mismatch_total++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result_mon.header_status !== want.status)
                    begin
                        $display("%0t: header_status expected %0d got %0d", $time,
                                 want.status, result_mon.header_status);
                        mismatch_total++;
                    end
                    if (result_mon.deflate_offset !== want.offset)
                    begin
                        $display("%0t: deflate_offset expected %0d got %0d", $time,
                                 want.offset, result_mon.deflate_offset);
                        mismatch_total++;
                    end
                end
            end
        end
        verdicts_due = pending_verdicts.size();
    end

endmodule

[verif/gzip_member_header_parser_tb.sv]
`timescale 1ns / 1ps

module gzip_member_header_parser_tb;
    import gmhp_pkg::*;

    localparam int ITEM_TARGET   = 1450;   // member bytes pushed before the random part ends
    localparam int MAX_GAP       = 6;      // longest idle per beat on either side
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off, fills the block up
    localparam int DRAIN_LIMIT   = 5000;   // cycles allowed for the last results to show
    localparam int SETTLE_CYCLES = 8;      // extra wait after the drain, for stray results
    localparam int FIELD_CAP     = 48;     // most extra field bytes actually pushed per member

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   header_bytes_sent;
    int   verdicts_taken;
    bit   sender_calm;
    bit   receiver_calm;

    // current member being built, and its header size without the tail
    logic [7:0]  member_q[$];
    logic [31:0] member_len;
    int          header_span;

    gmhp_in_if  byte_ch ();
    gmhp_out_if result_ch ();

    gzip_member_header_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .member_bytes  (byte_ch),
        .header_result (result_ch)
    );

    // watches both channels, predicts every header verdict and compares
    gmhp_header_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes_mon   (byte_ch),
        .result_mon  (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offer one beat after a random idle, hold it until the block takes it
    task automatic send_beat(input logic [7:0] data, input logic first,
                             input logic [31:0] len);
        int gap;
        // occasionally flip between bursty and back-to-back stretches
        if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid           <= 1'b1;
        byte_ch.data_byte       <= data;
        byte_ch.first_of_member <= first;
        byte_ch.member_length   <= len;
        do @(posedge clk); while (!byte_ch.ready);
        @(negedge clk);
    endtask

    // nul-ended string of n non-zero characters
    function automatic void add_string(input int n);
        repeat (n) member_q.push_back(8'($urandom_range(1, 255)));
        member_q.push_back(8'h00);
    endfunction

    // well-formed member header; length covers deflate_n data bytes plus the trailer,
    // and up to three data bytes are appended, which the block must ignore
    function automatic void build_member(input logic [7:0] flag_byte, input int xlen,
                                         input int name_n, input int comment_n,
                                         input int deflate_n);
        member_q.delete();
        member_q.push_back(MAGIC_ID1);
        member_q.push_back(MAGIC_ID2);
        member_q.push_back(METHOD_DEFLATE);
        member_q.push_back(flag_byte);
        // mtime, xfl, os
        repeat (FIXED_HDR_LEN - 4) member_q.push_back(8'($urandom));
        if (flag_byte[FB_EXTRA])
        begin
            member_q.push_back(xlen[7:0]);
            member_q.push_back(xlen[15:8]);
            // huge extra fields are cut short; such members overrun or never finish
            repeat (xlen < FIELD_CAP ? xlen : FIELD_CAP) member_q.push_back(8'($urandom));
        end
        if (flag_byte[FB_NAME]) add_string(name_n);
        if (flag_byte[FB_COMMENT]) add_string(comment_n);
        if (flag_byte[FB_HCRC]) repeat (HCRC_LEN) member_q.push_back(8'($urandom));
        header_span = member_q.size();
        member_len  = header_span + deflate_n + TRAILER_LEN;
        repeat (deflate_n < 3 ? deflate_n : 3) member_q.push_back(8'($urandom));
    endfunction

    // first beat carries the length, the rest carry junk in member_length
    task automatic send_member(input int count);
        for (int i = 0; i < count && i < member_q.size(); i++)
        begin
            send_beat(member_q[i], i == 0, (i == 0) ? member_len : $urandom);
            header_bytes_sent++;
        end
    endtask

    // result side: random stall per beat, plus two long hold-offs
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // while held off the sender keeps going, so results back up into the input
            if (verdicts_taken == 5 || verdicts_taken == 80)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            verdicts_taken++;
            @(negedge clk);
        end
    end

    // main stimulus and verdict
    initial
    begin
        int          pick;
        int          count;
        int          xlen;
        int          idx;
        int          drain;
        logic [7:0]  flag_byte;

        rst_n                   = 1'b0;
        byte_ch.valid           = 1'b0;
        byte_ch.data_byte       = 8'h00;
        byte_ch.first_of_member = 1'b0;
        byte_ch.member_length   = 32'd0;
        header_bytes_sent       = 0;
        verdicts_taken          = 0;
        sender_calm             = 1'b0;
        receiver_calm           = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: stray byte before any member start is dropped silently
        send_beat(8'hFF, 1'b0, 32'hFFFF_FFFF);
        // too short, zero and one below the minimum
        send_beat(MAGIC_ID1, 1'b1, 32'd0);
        send_beat(MAGIC_ID1, 1'b1, MIN_MEMBER_LEN - 1);
        // first magic byte wrong, longest length
        send_beat(8'h00, 1'b1, 32'hFFFF_FFFF);
        // second magic byte wrong
        send_beat(MAGIC_ID1, 1'b1, MIN_MEMBER_LEN);
        send_beat(8'h8A, 1'b0, 32'd0);
        // wrong compression method
        send_beat(MAGIC_ID1, 1'b1, MIN_MEMBER_LEN);
        send_beat(MAGIC_ID2, 1'b0, 32'd0);
        send_beat(8'h07, 1'b0, 32'd0);
        // every flag bit set, reserved ones too, with empty fields
        build_member(8'hFF, 0, 0, 0, 1);
        send_member(header_span);

        // random members: mostly well formed, some with tight or bogus lengths,
        // broken magic, cut-off members and stray bytes in between
        while (header_bytes_sent < ITEM_TARGET)
        begin
            pick      = $urandom_range(0, 99);
            flag_byte = 8'($urandom);
            xlen      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 6);
            build_member(flag_byte, xlen, $urandom_range(0, 5), $urandom_range(0, 5),
                         $urandom_range(1, 20));
            if (pick < 12)
                member_len = $urandom_range(MIN_MEMBER_LEN, header_span + TRAILER_LEN);
            else if (pick < 18)
                member_len = header_span + TRAILER_LEN;   // no room left for data
            else if (pick < 23)
                member_len = $urandom;
            else if (pick < 28)
                member_len = $urandom_range(0, MIN_MEMBER_LEN - 1);
            if ($urandom_range(0, 11) == 0)
            begin
                idx           = $urandom_range(0, 2);
                member_q[idx] = member_q[idx] ^ 8'($urandom_range(1, 255));
            end
            count = ($urandom_range(0, 19) == 0) ? $urandom_range(1, member_q.size())
                                                 : member_q.size();
            send_member(count);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0, $urandom);
        end
        byte_ch.valid <= 1'b0;

        // let the last results come out, then watch a little longer for strays
        drain = 0;
        while (outstanding != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (outstanding != 0)
            $display("%0t: %0d expected header results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("gzip_member_header_parser test passed");
        else
            $display("gzip_member_header_parser test failed");
        $finish;
    end

    // hard stop for a hung handshake
    initial
    begin
        #2_000_000;
        $display("gzip_member_header_parser test failed");
        $finish;
    end

endmodule
